/* rtl/i2c_register_transaction_master_assert.svh */
// Assertion helpers shared by the RTL. Both expect signals named clock and
// reset in the module that uses them.
`ifndef I2C_REGISTER_TRANSACTION_MASTER_ASSERT_SVH
`define I2C_REGISTER_TRANSACTION_MASTER_ASSERT_SVH

// same-cycle implication
`define I2CRTM_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define I2CRTM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/i2crtm_pkg.sv */
package i2crtm_pkg;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_BURST = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDR   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_START   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_LENGTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD   = 3'd4;

   // reset values
   localparam logic [7:0] RST_DEVICE_ADDR  = 8'd166;
   localparam logic [7:0] RST_BURST_START  = 8'd50;
   localparam logic [5:0] RST_BURST_LENGTH = 6'd6;
   localparam logic [9:0] RST_ACK_TIMEOUT  = 10'd250;
   localparam logic [9:0] RST_HALF_PERIOD  = 10'd5;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_data;
      logic       read_last;
      logic       done_res;
      logic       nack_error;
   } rsp_type;

   typedef struct packed {
      logic [7:0] device_write_address;
      logic [7:0] burst_start_register;
      logic [5:0] burst_length;
      logic [9:0] ack_timeout_ticks;
      logic [9:0] half_period_ticks;
   } cfg_type;

endpackage

/* rtl/i2crtm_core.sv */
`include "i2c_register_transaction_master_assert.svh"

module i2crtm_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  i2crtm_pkg::req_type req_word,
   input  i2crtm_pkg::cfg_type cfg,
   output i2crtm_pkg::rsp_type rsp_word
);
   import i2crtm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_HI, PH_START_FALL, PH_START_LOW,
      PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_WAIT,
      PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW, PH_MACK_HIGH,
      PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_REL, PH_RSTART_LOW
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [9:0] tick_ff, tick_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [5:0] byte_ff, byte_in;
   logic [9:0] tmo_ff, tmo_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] lreg_ff, lreg_in;
   logic [7:0] ldata_ff, ldata_in;

   logic [9:0]  half;
   logic [9:0]  tmo_limit;
   logic [10:0] tick_inc;
   logic        ends;
   logic [9:0]  tick_adv;
   logic [3:0]  bit_inc;
   logic [5:0]  byte_inc;
   logic [5:0]  read_len;
   logic        is_last;
   logic [9:0]  tmo_inc;
   logic [7:0]  rx_shift;
   logic        is_read;

   always_comb begin
      half      = (cfg.half_period_ticks == '0) ? 10'd1 : cfg.half_period_ticks;
      tmo_limit = (cfg.ack_timeout_ticks == '0) ? 10'd1 : cfg.ack_timeout_ticks;
      tick_inc  = {1'b0, tick_ff} + 11'd1;
      ends      = tick_inc >= {1'b0, half};
      tick_adv  = ends ? 10'd0 : tick_inc[9:0];
      bit_inc   = bit_ff + 4'd1;
      byte_inc  = byte_ff + 6'd1;
      if (kind_ff == CMD_BURST) begin
         read_len = (cfg.burst_length == '0) ? 6'd1 : cfg.burst_length;
      end else begin
         read_len = 6'd1;
      end
      is_last  = byte_inc >= read_len;
      tmo_inc  = tmo_ff + 10'd1;
      rx_shift = {shift_ff[6:0], req_word.sda_in};
      is_read  = (kind_ff == CMD_READ) || (kind_ff == CMD_BURST);

      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      byte_in  = byte_ff;
      tmo_in   = tmo_ff;
      kind_in  = kind_ff;
      lreg_in  = lreg_ff;
      ldata_in = ldata_ff;

      rsp_word = '0;
      rsp_word.scl_level = 1'b1;

      case (phase_ff)
         PH_START_HI: begin
            tick_in = tick_adv;
            if (ends) phase_in = PH_START_FALL;
         end
         PH_START_FALL: begin
            rsp_word.sda_pull_low = 1'b1;
            tick_in = tick_adv;
            if (ends) phase_in = PH_START_LOW;
         end
         PH_START_LOW: begin
            rsp_word.scl_level    = 1'b0;
            rsp_word.sda_pull_low = 1'b1;
            tick_in = tick_adv;
            if (ends) begin
               bit_in   = '0;
               phase_in = PH_TX_LOW;
            end
         end
         PH_TX_LOW: begin
            rsp_word.scl_level    = 1'b0;
            rsp_word.sda_pull_low = ~shift_ff[7];
            tick_in = tick_adv;
            if (ends) phase_in = PH_TX_HIGH;
         end
         PH_TX_HIGH: begin
            rsp_word.sda_pull_low = ~shift_ff[7];
            tick_in = tick_adv;
            if (ends) begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_inc;
               if (bit_inc >= 4'd8) begin
                  tmo_in   = '0;
                  phase_in = PH_ACK_LOW;
               end else begin
                  phase_in = PH_TX_LOW;
               end
            end
         end
         PH_ACK_LOW: begin
            rsp_word.scl_level = 1'b0;
            tick_in = tick_adv;
            if (ends) phase_in = PH_ACK_WAIT;
         end
         PH_ACK_WAIT: begin
            tick_in = '0;
            if (!req_word.sda_in) begin
               // slave acked: pick the next byte of the sequence
               byte_in = byte_inc;
               bit_in  = '0;
               if (byte_inc == 6'd1) begin
                  shift_in = lreg_ff;
                  phase_in = PH_TX_LOW;
               end else if (kind_ff == CMD_WRITE && byte_inc == 6'd2) begin
                  shift_in = ldata_ff;
                  phase_in = PH_TX_LOW;
               end else if (is_read && byte_inc == 6'd2) begin
                  shift_in = cfg.device_write_address + 8'd1;
                  phase_in = PH_RSTART_LOW;
               end else if (is_read && byte_inc == 6'd3) begin
                  byte_in  = '0;
                  shift_in = '0;
                  phase_in = PH_RX_LOW;
               end else begin
                  phase_in = PH_STOP_LOW;
               end
            end else begin
               tmo_in = tmo_inc;
               if (tmo_inc >= tmo_limit) begin
                  // abort: cleared kind flags the error at stop
                  kind_in  = CMD_TICK;
                  phase_in = PH_STOP_LOW;
               end
            end
         end
         PH_RSTART_LOW: begin
            rsp_word.scl_level = 1'b0;
            tick_in = tick_adv;
            if (ends) phase_in = PH_START_HI;
         end
         PH_RX_LOW: begin
            rsp_word.scl_level = 1'b0;
            tick_in = tick_adv;
            if (ends) phase_in = PH_RX_HIGH;
         end
         PH_RX_HIGH: begin
            tick_in = tick_adv;
            if (ends) begin
               shift_in = rx_shift;
               bit_in   = bit_inc;
               if (bit_inc >= 4'd8) begin
                  rsp_word.read_valid = 1'b1;
                  rsp_word.read_data  = rx_shift;
                  rsp_word.read_last  = is_last;
                  phase_in = PH_MACK_LOW;
               end else begin
                  phase_in = PH_RX_LOW;
               end
            end
         end
         PH_MACK_LOW: begin
            rsp_word.scl_level    = 1'b0;
            rsp_word.sda_pull_low = ~is_last;
            tick_in = tick_adv;
            if (ends) phase_in = PH_MACK_HIGH;
         end
         PH_MACK_HIGH: begin
            rsp_word.sda_pull_low = ~is_last;
            tick_in = tick_adv;
            if (ends) begin
               if (is_last) begin
                  phase_in = PH_STOP_LOW;
               end else begin
                  byte_in  = byte_inc;
                  bit_in   = '0;
                  shift_in = '0;
                  phase_in = PH_RX_LOW;
               end
            end
         end
         PH_STOP_LOW: begin
            rsp_word.scl_level    = 1'b0;
            rsp_word.sda_pull_low = 1'b1;
            tick_in = tick_adv;
            if (ends) phase_in = PH_STOP_HIGH;
         end
         PH_STOP_HIGH: begin
            rsp_word.sda_pull_low = 1'b1;
            tick_in = tick_adv;
            if (ends) phase_in = PH_STOP_REL;
         end
         PH_STOP_REL: begin
            tick_in = tick_adv;
            if (ends) begin
               rsp_word.done_res   = 1'b1;
               rsp_word.nack_error = (kind_ff == CMD_TICK);
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (req_word.cmd != CMD_TICK) begin
               kind_in  = req_word.cmd;
               lreg_in  = (req_word.cmd == CMD_BURST) ? cfg.burst_start_register
                                                      : req_word.reg_addr;
               ldata_in = req_word.write_data;
               shift_in = cfg.device_write_address;
               bit_in   = '0;
               byte_in  = '0;
               tmo_in   = '0;
               tick_in  = '0;
               phase_in = PH_START_HI;
            end
         end
      endcase

      rsp_word.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         byte_ff  <= '0;
         tmo_ff   <= '0;
         kind_ff  <= '0;
         lreg_ff  <= '0;
         ldata_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         byte_ff  <= byte_in;
         tmo_ff   <= tmo_in;
         kind_ff  <= kind_in;
         lreg_ff  <= lreg_in;
         ldata_ff <= ldata_in;
      end
   end

   `I2CRTM_ASSERT_IMPLY(a_done_idle, rsp_word.done_res, !rsp_word.busy_res)
   `I2CRTM_ASSERT_IMPLY(a_err_with_done, rsp_word.nack_error, rsp_word.done_res)
   `I2CRTM_ASSERT_NEXT(a_cmd_starts,
      step && phase_ff == PH_IDLE && req_word.cmd != CMD_TICK, phase_ff == PH_START_HI)

endmodule

/* rtl/i2c_register_transaction_master.sv */
// I2C master for register write, register read and burst read transactions.
// Request channel (req_valid / req_stall / req_data): one word per bus timing
// tick, carrying a command and the sampled SDA level. A command other than
// tick-only starts a transaction when the master is idle; commands seen
// while busy are ignored, so the source keeps sending ticks.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one word per
// request word, in order, holding the SCL level, the SDA pull-down, busy,
// any received byte, and the done / nack pulses.
// Each response word is registered, in the output register or the skid.
// Throughput: one word per cycle while rsp_stall is low; the sequencer
// computes combinationally and its result lands in the output register.
// When the receiver stalls, the output register holds and one more request
// is parked in a skid register; after that req_stall rises until the
// response drains.
// csr_*: register writes, taken any cycle the write enable is high; only
// meant while the master is idle.
// Reset (synchronous, active high): sequencer idle, registers at defaults,
// both buffers empty.
`include "i2c_register_transaction_master_assert.svh"

module i2c_register_transaction_master (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  i2crtm_pkg::req_type                    req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output i2crtm_pkg::rsp_type                    rsp_data,
   input  logic                                   csr_write_en,
   input  logic [i2crtm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [i2crtm_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import i2crtm_pkg::*;

   cfg_type cfg_ff;
   rsp_type step_rsp;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    accept;
   logic    pop;

   // a word is taken whenever the skid slot is free
   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_write_address <= RST_DEVICE_ADDR;
         cfg_ff.burst_start_register <= RST_BURST_START;
         cfg_ff.burst_length         <= RST_BURST_LENGTH;
         cfg_ff.ack_timeout_ticks    <= RST_ACK_TIMEOUT;
         cfg_ff.half_period_ticks    <= RST_HALF_PERIOD;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEVICE_ADDR:  cfg_ff.device_write_address <= csr_write_data[7:0];
            CSR_BURST_START:  cfg_ff.burst_start_register <= csr_write_data[7:0];
            CSR_BURST_LENGTH: cfg_ff.burst_length         <= csr_write_data[5:0];
            CSR_ACK_TIMEOUT:  cfg_ff.ack_timeout_ticks    <= csr_write_data;
            CSR_HALF_PERIOD:  cfg_ff.half_period_ticks    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // bus sequencer: state advances once per accepted word
   i2crtm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .req_word (req_data),
      .cfg      (cfg_ff),
      .rsp_word (step_rsp)
   );

   // output register plus one skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : step_rsp;
      end else if (accept) begin
         skid_ff <= step_rsp;
      end
   end

   `I2CRTM_ASSERT_IMPLY(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `I2CRTM_ASSERT_NEXT(a_skid_fills, accept && out_valid_ff && rsp_stall, skid_valid_ff)
   `I2CRTM_ASSERT_NEXT(a_skid_drains, !out_valid_ff || !rsp_stall, !skid_valid_ff)

endmodule
